[rtl/core/gstk_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, field widths and control structs for the grouped-sum top-k tracker.
// It has no dependencies. Every module of the block imports it.
package gstk_pkg;

   localparam int TOP_COUNT = 100;

   localparam int KEY_W   = 40;
   localparam int VAL_W   = 64;
   localparam int RANK_W  = 7;
   localparam int HELD_W  = 7;
   localparam int KIND_W  = 2;
   localparam int ENTRY_W = VAL_W + KEY_W;

   // Count of held entries runs 0..TOP_COUNT; a table index runs 0..TOP_COUNT-1.
   localparam int CNT_W = $clog2(TOP_COUNT + 1);
   localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

   localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   typedef struct packed {
      logic              go;
      logic              op_read;
      logic [VAL_W-1:0]  balance;
      logic [KEY_W-1:0]  address;
      logic [RANK_W-1:0] rank;
   } tbl_cmd_type;

   typedef struct packed {
      logic             done;
      logic             hit;
      logic [VAL_W-1:0] balance;
      logic [KEY_W-1:0] address;
      logic [CNT_W-1:0] count;
   } tbl_sts_type;

   typedef struct packed {
      logic start;
      logic add;
      logic close;
   } grp_ctl_type;

endpackage

[rtl/core/gstk_group.sv]
`timescale 1ns / 1ps
// Group accumulator: open flag, group address and the wrapping 64-bit running sum.
// Depends on gstk_pkg for widths and the control struct.
module gstk_group import gstk_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  grp_ctl_type      ctl,
   input  logic [KEY_W-1:0] address,
   input  logic [VAL_W-1:0] value,
   input  logic             spent,
   output logic             group_open,
   output logic [KEY_W-1:0] group_address,
   output logic [VAL_W-1:0] group_sum,
   output logic             address_match
);

   logic             open_ff, open_in;
   logic [KEY_W-1:0] addr_ff, addr_in;
   logic [VAL_W-1:0] sum_ff, sum_in;
   logic [VAL_W-1:0] addend;

   assign addend = spent ? '0 : value;

   always_comb begin
      open_in = open_ff;
      addr_in = addr_ff;
      sum_in  = sum_ff;
      if (ctl.start) begin
         open_in = 1'b1;
         addr_in = address;
         sum_in  = addend;
      end else if (ctl.add) begin
         sum_in = sum_ff + addend;
      end else if (ctl.close) begin
         open_in = 1'b0;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         addr_ff <= '0;
         sum_ff  <= '0;
      end else begin
         open_ff <= open_in;
         addr_ff <= addr_in;
         sum_ff  <= sum_in;
      end
   end

   assign group_open    = open_ff;
   assign group_address = addr_ff;
   assign group_sum     = sum_ff;
   assign address_match = (address == addr_ff);

endmodule

[rtl/core/gstk_table.sv]
`timescale 1ns / 1ps
// Sorted balance table: entry memory, binary search on one comparator, and a shift sequencer.
// Depends on gstk_pkg for widths, the command struct and the status struct.
module gstk_table import gstk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tbl_cmd_type cmd,
   output tbl_sts_type sts
);

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_RD    = 3'd1;
   localparam logic [2:0] T_SRCH  = 3'd2;
   localparam logic [2:0] T_CMP   = 3'd3;
   localparam logic [2:0] T_PLAN  = 3'd4;
   localparam logic [2:0] T_SHIFT = 3'd5;
   localparam logic [2:0] T_DRAIN = 3'd6;
   localparam logic [2:0] T_FIN   = 3'd7;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TOP_COUNT);
   localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);
   localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);

   logic [ENTRY_W-1:0] mem [TOP_COUNT];
   logic [ENTRY_W-1:0] rdata_ff;

   logic [2:0]       st_ff, st_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic             dup_ff, dup_in;
   logic             hit_ff, hit_in;
   logic [VAL_W-1:0] key_bal_ff, key_bal_in;
   logic [KEY_W-1:0] key_addr_ff, key_addr_in;
   logic [IDX_W-1:0] src_ff, src_in;
   logic [IDX_W-1:0] end_ff, end_in;
   logic             up_ff, up_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pdst_ff, pdst_in;
   logic             ins_en_ff, ins_en_in;
   logic [IDX_W-1:0] ins_pos_ff, ins_pos_in;
   logic [CNT_W-1:0] newcnt_ff, newcnt_in;

   logic               we;
   logic [IDX_W-1:0]   wa;
   logic [ENTRY_W-1:0] wd;
   logic [IDX_W-1:0]   ra;
   logic               done;

   logic                    full;
   logic [CNT_W:0]          mid_sum;
   logic [CNT_W-1:0]        mid_c;
   logic [CNT_W-1:0]        lo_m1;
   logic [CNT_W-1:0]        cnt_m1;
   logic [VAL_W-1:0]        rd_bal;
   logic [KEY_W-1:0]        rd_addr;
   logic [RANK_W+IDX_W-1:0] rank_ext;
   logic                    rank_hit;

   assign full     = (count_ff == FULL_COUNT);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_c    = mid_sum[CNT_W:1];
   assign lo_m1    = lo_ff - CNT_ONE;
   assign cnt_m1   = count_ff - CNT_ONE;
   assign rd_bal   = rdata_ff[ENTRY_W-1:KEY_W];
   assign rd_addr  = rdata_ff[KEY_W-1:0];
   assign rank_ext = {{IDX_W{1'b0}}, cmd.rank};
   assign rank_hit = ({{CNT_W{1'b0}}, cmd.rank} < {{RANK_W{1'b0}}, count_ff});

   always_comb begin
      st_in       = st_ff;
      count_in    = count_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      dup_in      = dup_ff;
      hit_in      = hit_ff;
      key_bal_in  = key_bal_ff;
      key_addr_in = key_addr_ff;
      src_in      = src_ff;
      end_in      = end_ff;
      up_in       = up_ff;
      pend_in     = pend_ff;
      pdst_in     = pdst_ff;
      ins_en_in   = ins_en_ff;
      ins_pos_in  = ins_pos_ff;
      newcnt_in   = newcnt_ff;
      we          = 1'b0;
      wa          = pdst_ff;
      wd          = rdata_ff;
      ra          = src_ff;
      done        = 1'b0;

      case (st_ff)
         T_IDLE: begin
            ra = rank_ext[IDX_W-1:0];
            if (cmd.go) begin
               if (cmd.op_read) begin
                  hit_in = rank_hit;
                  st_in  = T_RD;
               end else begin
                  key_bal_in  = cmd.balance;
                  key_addr_in = cmd.address;
                  lo_in       = '0;
                  hi_in       = count_ff;
                  dup_in      = 1'b0;
                  st_in       = T_SRCH;
               end
            end
         end

         T_RD: begin
            done  = 1'b1;
            st_in = T_IDLE;
         end

         // Lower-bound search: lo ends on the first entry not below the key.
         T_SRCH: begin
            ra     = mid_c[IDX_W-1:0];
            mid_in = mid_c;
            if (lo_ff < hi_ff) begin
               st_in = T_CMP;
            end else begin
               st_in = T_PLAN;
            end
         end

         T_CMP: begin
            if (rd_bal < key_bal_ff) begin
               lo_in = mid_ff + CNT_ONE;
            end else begin
               hi_in = mid_ff;
            end
            if (rd_bal == key_bal_ff) begin
               dup_in = 1'b1;
            end
            st_in = T_SRCH;
         end

         T_PLAN: begin
            pend_in   = 1'b0;
            ins_en_in = 1'b0;
            newcnt_in = count_ff;
            st_in     = T_FIN;
            if (!full) begin
               if (!dup_ff) begin
                  ins_en_in  = 1'b1;
                  ins_pos_in = lo_ff[IDX_W-1:0];
                  newcnt_in  = count_ff + CNT_ONE;
                  if (lo_ff != count_ff) begin
                     up_in  = 1'b1;
                     src_in = cnt_m1[IDX_W-1:0];
                     end_in = lo_ff[IDX_W-1:0];
                     st_in  = T_SHIFT;
                  end
               end
            end else if (lo_ff != '0) begin
               // The key beats the lowest entry, so the lowest entry leaves first.
               if (dup_ff) begin
                  newcnt_in = cnt_m1;
                  if (cnt_m1 != '0) begin
                     up_in  = 1'b0;
                     src_in = IDX_ONE;
                     end_in = cnt_m1[IDX_W-1:0];
                     st_in  = T_SHIFT;
                  end
               end else begin
                  ins_en_in  = 1'b1;
                  ins_pos_in = lo_m1[IDX_W-1:0];
                  if (lo_m1 != '0) begin
                     up_in  = 1'b0;
                     src_in = IDX_ONE;
                     end_in = lo_m1[IDX_W-1:0];
                     st_in  = T_SHIFT;
                  end
               end
            end
         end

         // One entry read and the previous one written back each cycle.
         T_SHIFT: begin
            ra = src_ff;
            if (pend_ff) begin
               we = 1'b1;
               wa = pdst_ff;
               wd = rdata_ff;
            end
            pend_in = 1'b1;
            pdst_in = up_ff ? (src_ff + IDX_ONE) : (src_ff - IDX_ONE);
            if (src_ff == end_ff) begin
               st_in = T_DRAIN;
            end else begin
               src_in = up_ff ? (src_ff - IDX_ONE) : (src_ff + IDX_ONE);
            end
         end

         T_DRAIN: begin
            we      = pend_ff;
            wa      = pdst_ff;
            wd      = rdata_ff;
            pend_in = 1'b0;
            st_in   = T_FIN;
         end

         T_FIN: begin
            if (ins_en_ff) begin
               we = 1'b1;
               wa = ins_pos_ff;
               wd = {key_bal_ff, key_addr_ff};
            end
            count_in = newcnt_ff;
            done     = 1'b1;
            st_in    = T_IDLE;
         end

         default: begin
            st_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= T_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      dup_ff      <= dup_in;
      hit_ff      <= hit_in;
      key_bal_ff  <= key_bal_in;
      key_addr_ff <= key_addr_in;
      src_ff      <= src_in;
      end_ff      <= end_in;
      up_ff       <= up_in;
      pdst_ff     <= pdst_in;
      ins_en_ff   <= ins_en_in;
      ins_pos_ff  <= ins_pos_in;
      newcnt_ff   <= newcnt_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[ra];
   end

   assign sts.done    = done;
   assign sts.hit     = hit_ff;
   assign sts.balance = rd_bal;
   assign sts.address = rd_addr;
   assign sts.count   = count_ff;

endmodule

[rtl/core/grouped_sum_top_k_tracker_unit.sv]
`timescale 1ns / 1ps
// Top level of the grouped-sum top-k tracker: stream handshakes, item sequencing, result register.
// Depends on gstk_pkg, gstk_group and gstk_table.
//
//   Channel  Dir  Ports                          Beat contents
//   req      in   req_tvalid/tready/tdata/tuser  one record, end marker or rank read
//   rsp      out  rsp_tvalid/tready/tdata        one result per request beat
//
// A record that stays in or opens a group, an end with no open group and an unused kind
// pass through S_DISP and S_RESULT into the result register; a rank read also passes
// S_READ. Closing a group offers its balance to the table: a binary search over one
// comparator (at most ceil(log2(n+1)) steps for n held entries, and a full table holds
// 100), then the memory port moves one entry per cycle. Reset is synchronous and
// clears the group state and the held count; table contents are never read before
// they are written. req_tready is high only while no beat is in work; a result waiting
// on rsp_tready does not block the next request until that request's own result is due.
module grouped_sum_top_k_tracker_unit import gstk_pkg::*; (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata, low bit up: address_key[39:0], output_value[63:0], spent, rank[6:0]
   input  logic [111:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]   req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata, low bit up: entry_valid, entry_balance[63:0], entry_address[39:0],
   // held_count[6:0]
   output logic [111:0] rsp_tdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DISP   = 3'd1;
   localparam logic [2:0] S_OFFER  = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0] st_ff, st_in;

   // The accepted request beat, held while it is worked on.
   logic [KIND_W-1:0] kind_ff;
   logic [KEY_W-1:0]  addr_ff;
   logic [VAL_W-1:0]  value_ff;
   logic              spent_ff;
   logic [RANK_W-1:0] rank_ff;

   // Read result captured from the table before it is packed.
   logic             res_hit_ff, res_hit_in;
   logic [VAL_W-1:0] res_bal_ff, res_bal_in;
   logic [KEY_W-1:0] res_addr_ff, res_addr_in;

   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [111:0] rsp_tdata_ff, rsp_tdata_in;

   logic req_beat;
   logic out_free;

   grp_ctl_type      grp_ctl;
   logic             grp_open;
   logic [KEY_W-1:0] grp_addr;
   logic [VAL_W-1:0] grp_sum;
   logic             grp_match;

   tbl_cmd_type tbl_cmd;
   tbl_sts_type tbl_sts;

   logic [CNT_W+HELD_W-1:0] held_ext;
   logic [HELD_W-1:0]       held;

   assign req_tready = (st_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign held_ext = {{HELD_W{1'b0}}, tbl_sts.count};
   assign held     = held_ext[HELD_W-1:0];

   gstk_group u_group (
      .clock         (clock),
      .reset         (reset),
      .ctl           (grp_ctl),
      .address       (addr_ff),
      .value         (value_ff),
      .spent         (spent_ff),
      .group_open    (grp_open),
      .group_address (grp_addr),
      .group_sum     (grp_sum),
      .address_match (grp_match)
   );

   gstk_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .sts   (tbl_sts)
   );

   always_comb begin
      st_in         = st_ff;
      res_hit_in    = res_hit_ff;
      res_bal_in    = res_bal_ff;
      res_addr_in   = res_addr_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      grp_ctl         = '0;
      tbl_cmd.go      = 1'b0;
      tbl_cmd.op_read = (kind_ff == KIND_READ);
      tbl_cmd.balance = grp_sum;
      tbl_cmd.address = grp_addr;
      tbl_cmd.rank    = rank_ff;

      case (st_ff)
         S_IDLE: begin
            if (req_beat) begin
               st_in = S_DISP;
            end
         end

         S_DISP: begin
            res_hit_in  = 1'b0;
            res_bal_in  = '0;
            res_addr_in = '0;
            st_in       = S_RESULT;
            case (kind_ff)
               KIND_RECORD: begin
                  if (grp_open && !grp_match) begin
                     // A new address closes the running group first.
                     tbl_cmd.go = 1'b1;
                     st_in      = S_OFFER;
                  end else if (grp_open) begin
                     grp_ctl.add = 1'b1;
                  end else begin
                     grp_ctl.start = 1'b1;
                  end
               end
               KIND_END: begin
                  if (grp_open) begin
                     tbl_cmd.go = 1'b1;
                     st_in      = S_OFFER;
                  end
               end
               KIND_READ: begin
                  tbl_cmd.go = 1'b1;
                  st_in      = S_READ;
               end
               default: begin
                  st_in = S_RESULT;
               end
            endcase
         end

         S_OFFER: begin
            if (tbl_sts.done) begin
               if (kind_ff == KIND_RECORD) begin
                  grp_ctl.start = 1'b1;
               end else begin
                  grp_ctl.close = 1'b1;
               end
               st_in = S_RESULT;
            end
         end

         S_READ: begin
            if (tbl_sts.done) begin
               res_hit_in  = tbl_sts.hit;
               res_bal_in  = tbl_sts.hit ? tbl_sts.balance : '0;
               res_addr_in = tbl_sts.hit ? tbl_sts.address : '0;
               st_in       = S_RESULT;
            end
         end

         S_RESULT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {held, res_addr_ff, res_bal_ff, res_hit_ff};
               st_in         = S_IDLE;
            end
         end

         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         kind_ff  <= req_tuser;
         addr_ff  <= req_tdata[39:0];
         value_ff <= req_tdata[103:40];
         spent_ff <= req_tdata[104];
         rank_ff  <= req_tdata[111:105];
      end
      res_hit_ff   <= res_hit_in;
      res_bal_ff   <= res_bal_in;
      res_addr_ff  <= res_addr_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[test/tb_grouped_sum_top_k_tracker_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for grouped_sum_top_k_tracker_unit: directed and random request beats,
// with every result beat checked against a table predictor. Depends on gstk_pkg and the RTL.
module tb_grouped_sum_top_k_tracker_unit;
   import gstk_pkg::*;

   localparam int HALF_PERIOD      = 4;
   localparam int RESET_CYCLES     = 6;
   localparam int BEAT_W           = 112;
   localparam int TARGET_ITEMS     = 1200;
   localparam int HOLD_AT_ITEM     = 500;
   localparam int DRAIN_AT_ITEM    = 850;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES      = 150;
   localparam int WATCHDOG_LIMIT   = 4000;

   // The package names the three live kinds; the fourth code is ignored by the block.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum {GROUP_RANDOM, GROUP_SMALL, GROUP_TIE} group_style_type;

   // Request tdata, packed from the lowest bit up: address, value, spent, rank.
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              spent;
      logic [VAL_W-1:0]  value;
      logic [KEY_W-1:0]  address;
   } req_fields_type;

   // Result tdata, packed from the lowest bit up: valid, balance, address, held count.
   typedef struct packed {
      logic [HELD_W-1:0] held_count;
      logic [KEY_W-1:0]  entry_address;
      logic [VAL_W-1:0]  entry_balance;
      logic              entry_valid;
   } rsp_fields_type;

   // Tracks the sorted top-balance table and the open group, and holds the result
   // beats still owed by the block, oldest first.
   class top_balance_ledger;
      logic [VAL_W-1:0] held_balance [TOP_COUNT];
      logic [KEY_W-1:0] held_address [TOP_COUNT];
      int unsigned      held_total;
      logic [KEY_W-1:0] group_key;
      logic [VAL_W-1:0] group_total;
      bit               group_live;
      rsp_fields_type   awaited_results [$];
      int unsigned      failures;

      function new();
         held_total  = 0;
         group_key   = '0;
         group_total = '0;
         group_live  = 1'b0;
         failures    = 0;
         foreach (held_balance[i]) begin
            held_balance[i] = '0;
            held_address[i] = '0;
         end
      endfunction

      function void remove_lowest();
         int unsigned i;
         for (i = 1; i < held_total; i++) begin
            held_balance[i-1] = held_balance[i];
            held_address[i-1] = held_address[i];
         end
         if (held_total > 0) held_total--;
      endfunction

      // Balances are unique: an equal balance already held leaves the table alone.
      function void insert_unique(logic [VAL_W-1:0] balance, logic [KEY_W-1:0] key);
         int unsigned pos;
         int unsigned i;
         if (held_total >= TOP_COUNT) return;
         pos = 0;
         while (pos < held_total && held_balance[pos] < balance) pos++;
         if (pos < held_total && held_balance[pos] == balance) return;
         for (i = held_total; i > pos; i--) begin
            held_balance[i] = held_balance[i-1];
            held_address[i] = held_address[i-1];
         end
         held_balance[pos] = balance;
         held_address[pos] = key;
         held_total++;
      endfunction

      // On a full table the lowest entry goes first, even if the insert then ties.
      function void offer_balance(logic [VAL_W-1:0] balance, logic [KEY_W-1:0] key);
         if (held_total < TOP_COUNT) begin
            insert_unique(balance, key);
         end else if (balance > held_balance[0]) begin
            remove_lowest();
            insert_unique(balance, key);
         end
      endfunction

      function void close_group();
         if (group_live) offer_balance(group_total, group_key);
         group_live  = 1'b0;
         group_total = '0;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, req_fields_type beat);
         rsp_fields_type want;
         want = '0;
         case (kind)
            KIND_RECORD: begin
               if (group_live && beat.address != group_key) close_group();
               if (!group_live) begin
                  group_live  = 1'b1;
                  group_key   = beat.address;
                  group_total = '0;
               end
               if (!beat.spent) group_total += beat.value;
            end
            KIND_END: begin
               close_group();
            end
            KIND_READ: begin
               if (beat.rank < held_total) begin
                  want.entry_valid   = 1'b1;
                  want.entry_balance = held_balance[beat.rank];
                  want.entry_address = held_address[beat.rank];
               end
            end
            default: begin
            end
         endcase
         want.held_count = HELD_W'(held_total);
         awaited_results.insert(awaited_results.size(), want);
      endfunction

      function void compare_field(string label, logic [VAL_W-1:0] want,
                                  logic [VAL_W-1:0] got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
            failures++;
         end
      endfunction

      function void check_result(logic [BEAT_W-1:0] tdata);
         rsp_fields_type got;
         rsp_fields_type want;
         got = tdata;
         if (awaited_results.size() == 0) begin
            $display("%0t ns: result beat with nothing awaited, expected none, actual %h",
                     $time, tdata);
            failures++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("entry_valid", VAL_W'(want.entry_valid), VAL_W'(got.entry_valid));
         compare_field("entry_balance", want.entry_balance, got.entry_balance);
         compare_field("entry_address", VAL_W'(want.entry_address),
                       VAL_W'(got.entry_address));
         compare_field("held_count", VAL_W'(want.held_count), VAL_W'(got.held_count));
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction
   endclass

   // All block inputs start at known values; reset is high from time zero.
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BEAT_W-1:0] req_tdata  = '0;
   logic [1:0]        req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BEAT_W-1:0] rsp_tdata;

   top_balance_ledger ledger = new();

   // Bench state; calm_phase and receiver_hold_pending are shared by the driver and the sink.
   bit          calm_phase            = 1'b0;
   bit          receiver_hold_pending = 1'b0;
   int unsigned items_sent            = 0;
   int unsigned quiet_cycles          = 0;

   always #HALF_PERIOD clock = ~clock;

   grouped_sum_top_k_tracker_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Gap lengths for both sides: mostly none or short, now and then a long one.
   // During a calm phase neither side idles at all.
   function automatic int unsigned idle_length();
      int unsigned roll;
      if (calm_phase) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VAL_W-1:0] random_value();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      return KEY_W'({$urandom, $urandom});
   endfunction

   // Offers one request beat and waits for the edge that takes it. The handshake is
   // sampled right after the rising edge, before any of that edge's updates land, so
   // it sees exactly what the block saw. With no gap, tvalid stays high and the caller
   // must put the next beat up in this same time step or lower tvalid.
   task automatic send_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                            logic [VAL_W-1:0] value, logic spent, logic [RANK_W-1:0] rank);
      req_fields_type beat;
      int unsigned gap;
      beat.address = key;
      beat.value   = value;
      beat.spent   = spent;
      beat.rank    = rank;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.note_request(kind, beat);
      if (kind != KIND_UNUSED) items_sent++;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Ranks mostly fall around the held count, so both hits and misses come up, and
   // now and then anywhere in the 7-bit range.
   task automatic send_read();
      int unsigned rank;
      if ($urandom_range(0, 3) == 0) rank = $urandom_range(0, 127);
      else rank = $urandom_range(0, ledger.held_total);
      send_item(KIND_READ, random_key(), random_value(), 1'($urandom), RANK_W'(rank));
   endtask

   // Sends the records of one group. A tie group first closes whatever is open, so the
   // table is settled, then copies a held balance: against a full table this drives
   // the case where the lowest entry is dropped and the insert still fails on a tie.
   task automatic send_group(logic [KEY_W-1:0] key, group_style_type style);
      int unsigned records;
      int unsigned i;
      logic [VAL_W-1:0] tie_balance;
      records = $urandom_range(1, 4);
      if (style == GROUP_TIE) begin
         send_item(KIND_END, random_key(), random_value(), 1'($urandom),
                   RANK_W'($urandom));
         if (ledger.held_total >= 2 && $urandom_range(0, 1) == 1)
            tie_balance = ledger.held_balance[$urandom_range(1, ledger.held_total - 1)];
         else
            tie_balance = ledger.held_balance[$urandom_range(0, ledger.held_total - 1)];
         send_item(KIND_RECORD, key, tie_balance, 1'b0, RANK_W'($urandom));
      end
      for (i = 0; i < records; i++) begin
         // An unused kind in the middle of a group must neither close nor change it.
         if ($urandom_range(0, 19) == 0)
            send_item(KIND_UNUSED, random_key(), random_value(), 1'($urandom),
                      RANK_W'($urandom));
         case (style)
            GROUP_SMALL:
               send_item(KIND_RECORD, key, VAL_W'($urandom_range(0, 7)), 1'($urandom),
                         RANK_W'($urandom));
            GROUP_TIE:
               send_item(KIND_RECORD, key, random_value(), 1'b1, RANK_W'($urandom));
            default:
               send_item(KIND_RECORD, key, random_value(), ($urandom_range(0, 4) == 0),
                         RANK_W'($urandom));
         endcase
      end
   endtask

   // Takes the request line down and waits until every owed result has come back.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Result sink: checks each accepted beat, stalls at random, and once holds off for
   // a long stretch while the driver keeps offering requests, so the block backs up.
   initial begin : result_sink
      int unsigned stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) ledger.check_result(rsp_tdata);
         if (receiver_hold_pending) begin
            receiver_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = ($urandom_range(0, 3) == 0) ? idle_length() : 0;
         end
      end
   end

   // Watchdog: any accepted beat on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat accepted for %0d cycles", $time, quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : request_driver
      logic [KEY_W-1:0] key;
      int unsigned      roll;
      bit               hold_done;
      bit               drain_done;
      bit               ended;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Reads on an empty table, at the lowest rank and the highest.
      send_item(KIND_READ, '0, '0, 1'b0, '0);
      send_item(KIND_READ, '1, '1, 1'b1, '1);
      // End with no open group offers nothing; the unused kind is ignored.
      send_item(KIND_END, '0, '0, 1'b0, '0);
      send_item(KIND_UNUSED, '1, '1, 1'b1, '1);
      // Two all-ones values wrap the group sum; a spent record adds nothing.
      send_item(KIND_RECORD, '0, '1, 1'b0, '1);
      send_item(KIND_RECORD, '0, '1, 1'b0, '0);
      send_item(KIND_RECORD, '0, '1, 1'b1, '0);
      // The highest address closes the first group and builds the same balance,
      // so its offer at the end is a tie and the table keeps one entry.
      send_item(KIND_RECORD, '1, {{(VAL_W-1){1'b1}}, 1'b0}, 1'b0, '0);
      send_item(KIND_END, '1, '0, 1'b0, '0);
      send_item(KIND_END, '0, '0, 1'b0, '0);
      send_item(KIND_READ, '0, '0, 1'b0, RANK_W'(0));
      send_item(KIND_READ, '0, '0, 1'b0, RANK_W'(1));
      // A zero balance goes in below the wrapped one; a second zero balance ties.
      send_item(KIND_RECORD, KEY_W'(5), '0, 1'b0, '0);
      send_item(KIND_RECORD, KEY_W'(6), '1, 1'b1, '0);
      send_item(KIND_UNUSED, KEY_W'(9), '1, 1'b0, '0);
      send_item(KIND_RECORD, KEY_W'(6), '0, 1'b0, '0);
      send_item(KIND_END, '0, '0, 1'b0, '0);
      send_item(KIND_READ, '0, '0, 1'b0, RANK_W'(0));
      send_item(KIND_READ, '0, '0, 1'b0, RANK_W'(1));
      send_item(KIND_READ, '0, '0, 1'b0, RANK_W'(2));
      // The driver waits here for every result before the random part starts.
      pause_until_drained();

      // Random part: well-formed groups with fresh addresses, mixed with reads, end
      // markers, repeated ends, reused addresses and the occasional ignored kind.
      key = KEY_W'(16);
      while (items_sent < TARGET_ITEMS) begin
         calm_phase = ((items_sent / 150) % 4) == 2;
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            receiver_hold_pending = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && items_sent >= DRAIN_AT_ITEM) begin
            pause_until_drained();
            drain_done = 1'b1;
         end

         roll = $urandom_range(0, 99);
         if (roll < 12 && ledger.held_total > 0) send_group(key, GROUP_TIE);
         else if (roll < 22) send_group(key, GROUP_SMALL);
         else send_group(key, GROUP_RANDOM);

         roll = $urandom_range(0, 9);
         if (roll < 3) begin
            repeat ($urandom_range(1, 3)) send_read();
         end
         ended = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            send_item(KIND_END, random_key(), random_value(), 1'($urandom),
                      RANK_W'($urandom));
            ended = 1'b1;
            if ($urandom_range(0, 3) == 0)
               send_item(KIND_END, random_key(), random_value(), 1'($urandom),
                         RANK_W'($urandom));
         end
         // After an end, the same address may start a new group of its own.
         if (!(ended && $urandom_range(0, 1) == 1))
            key = key + KEY_W'($urandom_range(1, 65536));
      end

      // Close the last group, read back a few entries, and let everything drain.
      send_item(KIND_END, '0, '0, 1'b0, '0);
      repeat (3) send_read();
      pause_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
